>>> sv/cpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types, constants and the byte-wise CRC-32 update for the packet
// decoder.
// ----------------------------------------------------------------------------
package cpd_pkg;

	localparam int unsigned MAX_PAYLOAD = 512;
	localparam int unsigned COUNT_W     = 10;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
	localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;

	// Configuration register indexes
	localparam logic [1:0] CFG_MAX_WINDOW = 2'd0;
	localparam logic [1:0] CFG_DATA_TYPE  = 2'd1;
	localparam logic [1:0] CFG_ACK_TYPE   = 2'd2;
	localparam logic [1:0] CFG_NACK_TYPE  = 2'd3;

	typedef enum logic [3:0] {
		ST_OK           = 4'd0,
		ST_NO_HEADER    = 4'd1,
		ST_BAD_TYPE     = 4'd2,
		ST_BAD_WINDOW   = 4'd3,
		ST_BAD_LENGTH   = 4'd4,
		ST_INCONSISTENT = 4'd5,
		ST_BAD_CRC      = 4'd6,
		ST_NO_PAYLOAD   = 4'd7,
		ST_BAD_PADDING  = 4'd8
	} status_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_packet;
	} in_t;

	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic        done_res;
		logic [3:0]  status;
		logic [2:0]  packet_type;
		logic [4:0]  window_size;
		logic [7:0]  sequence_number;
		logic [15:0] payload_length;
		logic [31:0] trailer_crc;
	} out_t;

	typedef struct packed {
		logic [4:0] max_window;
		logic [2:0] data_type_code;
		logic [2:0] ack_type_code;
		logic [2:0] nack_type_code;
	} cfg_t;

	// Header and check values handed to the verdict logic
	typedef struct packed {
		logic [COUNT_W-1:0] n;
		logic [2:0]         hdr_type;
		logic [4:0]         hdr_window;
		logic [15:0]        hdr_length;
		logic [31:0]        calc_crc;
		logic [31:0]        rx_crc;
	} chk_t;

	// Reflected CRC-32 update over one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] c;
		c = acc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

>>> sv/cpd_verdict.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpd_verdict
// Final packet status from header fields, byte count and CRC, in priority
// order.
// ----------------------------------------------------------------------------
module cpd_verdict (
	input  var cpd_pkg::chk_t    chk,
	input  var cpd_pkg::cfg_t    cfg,
	output cpd_pkg::status_t     status
);

	logic        type_known;
	logic [1:0]  pad;
	logic [16:0] total;

	assign type_known = (chk.hdr_type == cfg.data_type_code) ||
	                    (chk.hdr_type == cfg.ack_type_code)  ||
	                    (chk.hdr_type == cfg.nack_type_code);
	// Padding up to the next multiple of four
	assign pad   = 2'(3'd4 - {1'b0, chk.hdr_length[1:0]});
	assign total = 17'd8 + {1'b0, chk.hdr_length} + {15'd0, pad};

	always_comb begin
		if (chk.n < cpd_pkg::COUNT_W'(4))
			status = cpd_pkg::ST_NO_HEADER;
		else if (!type_known)
			status = cpd_pkg::ST_BAD_TYPE;
		else if (chk.hdr_window > cfg.max_window)
			status = cpd_pkg::ST_BAD_WINDOW;
		else if (chk.hdr_length > 16'(cpd_pkg::MAX_PAYLOAD))
			status = cpd_pkg::ST_BAD_LENGTH;
		else if (chk.n == cpd_pkg::COUNT_W'(4))
			status = cpd_pkg::ST_OK;
		else if (chk.hdr_type != cfg.data_type_code)
			status = cpd_pkg::ST_INCONSISTENT;
		else if (chk.n < cpd_pkg::COUNT_W'(8))
			status = cpd_pkg::ST_INCONSISTENT;
		else if ((chk.calc_crc ^ cpd_pkg::CRC_PRESET) != chk.rx_crc)
			status = cpd_pkg::ST_BAD_CRC;
		else if (chk.n == cpd_pkg::COUNT_MAX)
			status = cpd_pkg::ST_INCONSISTENT;
		else if (chk.n == cpd_pkg::COUNT_W'(8))
			status = cpd_pkg::ST_NO_PAYLOAD;
		else if (chk.n[1:0] != 2'd0)
			status = cpd_pkg::ST_BAD_PADDING;
		else if (total != 17'(chk.n))
			status = cpd_pkg::ST_INCONSISTENT;
		else
			status = cpd_pkg::ST_OK;
	end

endmodule
`default_nettype wire

>>> sv/cpd_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpd_core
// Per-packet state: byte counter, header capture, 4-byte delay line and
// CRC accumulator. Forms the result for the byte on its input.
// ----------------------------------------------------------------------------
module cpd_core (
	input  var logic          clk,
	input  var logic          arst_n,
	input  var logic          step,
	input  var cpd_pkg::in_t  item,
	input  var cpd_pkg::cfg_t cfg,
	output cpd_pkg::out_t     result,
	output logic              produces
);

	logic [cpd_pkg::COUNT_W-1:0] byte_count_q, count_n;
	logic [31:0]                 crc_q, crc_n;
	logic [7:0]                  dly_q [4];
	logic [2:0]                  hdr_type_q, type_n;
	logic [4:0]                  hdr_window_q, window_n;
	logic [7:0]                  hdr_seq_q, seq_n;
	logic [15:0]                 hdr_len_q, len_n;
	logic [7:0]                  b, leaving;
	logic [31:0]                 rx_crc;
	logic                        pv, last;
	cpd_pkg::chk_t               chk;
	cpd_pkg::status_t            status;

	assign b       = item.rx_byte;
	assign last    = item.end_of_packet;
	assign leaving = dly_q[0];

	// Header capture
	always_comb begin
		type_n   = hdr_type_q;
		window_n = hdr_window_q;
		seq_n    = hdr_seq_q;
		len_n    = hdr_len_q;
		case (byte_count_q)
			cpd_pkg::COUNT_W'(0): begin
				type_n   = b[7:5];
				window_n = b[4:0];
			end
			cpd_pkg::COUNT_W'(1): seq_n = b;
			cpd_pkg::COUNT_W'(2): len_n = {b, hdr_len_q[7:0]};
			cpd_pkg::COUNT_W'(3): len_n = {hdr_len_q[15:8], b};
			default: ;
		endcase
	end

	assign crc_n   = (byte_count_q >= cpd_pkg::COUNT_W'(4)) ?
	                 cpd_pkg::crc_byte(crc_q, leaving) : crc_q;
	assign count_n = (byte_count_q == cpd_pkg::COUNT_MAX) ?
	                 byte_count_q : byte_count_q + cpd_pkg::COUNT_W'(1);
	assign pv      = (byte_count_q != cpd_pkg::COUNT_MAX) &&
	                 (byte_count_q >= cpd_pkg::COUNT_W'(8)) &&
	                 (16'(byte_count_q - cpd_pkg::COUNT_W'(8)) < len_n);
	assign rx_crc  = {dly_q[1], dly_q[2], dly_q[3], b};

	assign chk.n          = count_n;
	assign chk.hdr_type   = type_n;
	assign chk.hdr_window = window_n;
	assign chk.hdr_length = len_n;
	assign chk.calc_crc   = crc_n;
	assign chk.rx_crc     = rx_crc;

	cpd_verdict u_verdict (
		.chk    (chk),
		.cfg    (cfg),
		.status (status)
	);

	always_comb begin
		result                 = '0;
		result.payload_valid   = pv;
		result.payload_byte    = pv ? leaving : 8'd0;
		result.done_res        = last;
		if (last) begin
			result.status          = status;
			result.packet_type     = type_n;
			result.window_size     = window_n;
			result.sequence_number = seq_n;
			result.payload_length  = len_n;
			result.trailer_crc     = rx_crc;
		end
	end

	assign produces = pv || last;

	// Advance on each byte; rearm after the final one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			crc_q        <= cpd_pkg::CRC_PRESET;
			dly_q        <= '{default: 8'd0};
			hdr_type_q   <= '0;
			hdr_window_q <= '0;
			hdr_seq_q    <= '0;
			hdr_len_q    <= '0;
		end else if (step) begin
			if (last) begin
				byte_count_q <= '0;
				crc_q        <= cpd_pkg::CRC_PRESET;
				dly_q        <= '{default: 8'd0};
				hdr_type_q   <= '0;
				hdr_window_q <= '0;
				hdr_seq_q    <= '0;
				hdr_len_q    <= '0;
			end else begin
				byte_count_q <= count_n;
				crc_q        <= crc_n;
				dly_q        <= '{dly_q[1], dly_q[2], dly_q[3], b};
				hdr_type_q   <= type_n;
				hdr_window_q <= window_n;
				hdr_seq_q    <= seq_n;
				hdr_len_q    <= len_n;
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/crc_checked_packet_decoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc_checked_packet_decoder_top
// Byte-stream packet deframer with header checks and trailing CRC-32.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data): one raw byte per transaction,
// end_of_packet marking the final byte of a packet. Output channel
// (out_valid/out_ready/out_data): one transaction per payload byte leaving
// the 4-byte delay line within the declared length, and one on the final
// byte carrying done_res, status, the header fields and the received CRC.
// Bytes that produce nothing (header, CRC tail, padding) yield no
// transaction.
// Path: a byte accepted is held in the input register, is processed from
// there, and its result is loaded into the output register that drives out_data.
// Throughput: one byte per cycle unless the output side stalls; the CRC update,
// header capture and status checks all sit between the two registers.
// Stall: while out_ready is low the output register holds; one more byte
// waits in the input register, then in_ready drops. Bytes that produce no
// result still move on while the output side is stalled.
// Reset (arst_n low): configuration returns to max_window 31, type codes
// 1/2/3; the packet state clears (counter 0, CRC preset, empty delay line).
// Configuration writes (cfg_we/cfg_index/cfg_wdata) take effect at once. The
// user must write only while no packet is in flight; no logic enforces it.
// ----------------------------------------------------------------------------
module crc_checked_packet_decoder_top (
	input  var logic          clk,
	input  var logic          arst_n,
	input  var logic          in_valid,
	output logic              in_ready,
	input  var cpd_pkg::in_t  in_data,
	output logic              out_valid,
	input  var logic          out_ready,
	output cpd_pkg::out_t     out_data,
	input  var logic          cfg_we,
	input  var logic [1:0]    cfg_index,
	input  var logic [4:0]    cfg_wdata
);

	cpd_pkg::cfg_t cfg_q;
	cpd_pkg::in_t  rx_s1;
	logic          valid_s1;
	cpd_pkg::out_t out_q;
	logic          out_valid_q;
	cpd_pkg::out_t result;
	logic          produces;
	logic          out_free;
	logic          advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_window     <= 5'd31;
			cfg_q.data_type_code <= 3'd1;
			cfg_q.ack_type_code  <= 3'd2;
			cfg_q.nack_type_code <= 3'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cpd_pkg::CFG_MAX_WINDOW: cfg_q.max_window     <= cfg_wdata;
				cpd_pkg::CFG_DATA_TYPE:  cfg_q.data_type_code <= cfg_wdata[2:0];
				cpd_pkg::CFG_ACK_TYPE:   cfg_q.ack_type_code  <= cfg_wdata[2:0];
				cpd_pkg::CFG_NACK_TYPE:  cfg_q.nack_type_code <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// Advance the held byte when its result has somewhere to go, or when it
	// produces no result at all.
	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (!produces || out_free);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_s1 <= in_data;
		end
	end

	cpd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.item     (rx_s1),
		.cfg      (cfg_q),
		.result   (result),
		.produces (produces)
	);

	// Output register: load a fresh result, or drop the one just taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && produces) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produces) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Every result carries a payload byte or a verdict
	a_no_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.payload_valid || out_q.done_res))
		else $error("empty result transaction");

	// Verdict fields stay clear on plain payload transactions
	a_clear_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.done_res) |->
		(out_q.status == 4'd0 && out_q.trailer_crc == 32'd0 &&
		 out_q.payload_length == 16'd0))
		else $error("verdict fields set without done_res");

	// A held byte that cannot move keeps its place in the input register
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(rx_s1)))
		else $error("input register lost a stalled byte");

	// A produced result is always loaded into the output register
	a_load_out: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && produces) |=> out_valid_q)
		else $error("result dropped");

endmodule
`default_nettype wire

>>> dv/tb_crc_checked_packet_decoder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_crc_checked_packet_decoder_top
// Self-checking bench for the CRC-checked packet deframer. A queue of bytes
// feeds a valid/ready driver. A monitor compares every output transaction
// with a cycle-free model of the deframer that is updated on each accepted
// input byte. The first part is short directed frames. Six configuration
// phases follow, each with mostly well-formed frames and some broken ones.
// ----------------------------------------------------------------------------
module tb_crc_checked_packet_decoder_top;
	import cpd_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT    = 14;
	localparam int PHASE_BYTES = 135;
	localparam int PRINT_CAP   = 100;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	in_t        in_data   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_t       out_data;
	logic       cfg_we    = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [4:0] cfg_wdata = '0;

	// Stimulus and scoreboard stores
	in_t        rx_stream[$];    // bytes waiting to be driven
	out_t       due_results[$];  // decoder results still to arrive
	logic [7:0] frame[$];        // frame under construction
	int         errors      = 0;
	int         cycle_count = 0;
	bit         steady      = 1'b0;  // suppress all idling on both sides

	// Model copy of the configuration registers (reset values)
	logic [4:0] lim_window = 5'd31;
	logic [2:0] code_data  = 3'd1;
	logic [2:0] code_ack   = 3'd2;
	logic [2:0] code_nack  = 3'd3;

	// Model copy of the per-packet state
	logic [9:0]  rx_count;
	logic [31:0] crc_run;
	logic [7:0]  tail[4];
	logic [2:0]  hdr_type;
	logic [4:0]  hdr_win;
	logic [7:0]  hdr_seq;
	logic [15:0] hdr_len;

	crc_checked_packet_decoder_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------------
	// Model of the deframer
	// ------------------------------------------------------------------------

	// Reflected CRC-32, one byte, bit by bit
	function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] c;
		logic        lsb;
		c = acc ^ {24'd0, b};
		repeat (8) begin
			lsb = c[0];
			c   = {1'b0, c[31:1]};
			if (lsb) c ^= 32'hEDB88320;
		end
		return c;
	endfunction

	function void clear_packet();
		rx_count = '0;
		crc_run  = '1;
		foreach (tail[i]) tail[i] = '0;
		hdr_type = '0;
		hdr_win  = '0;
		hdr_seq  = '0;
		hdr_len  = '0;
	endfunction

	// Verdict on the final byte; the order of the checks matters
	function status_t judge(input logic [9:0] n, input logic [31:0] rx_crc);
		logic [1:0]  pad;
		logic [17:0] span;
		if (n < 10'd4) return ST_NO_HEADER;
		if (hdr_type != code_data && hdr_type != code_ack && hdr_type != code_nack)
			return ST_BAD_TYPE;
		if (hdr_win > lim_window) return ST_BAD_WINDOW;
		if (hdr_len > MAX_PAYLOAD) return ST_BAD_LENGTH;
		if (n == 10'd4) return ST_OK;
		if (hdr_type != code_data) return ST_INCONSISTENT;
		if (n < 10'd8) return ST_INCONSISTENT;
		if (~crc_run != rx_crc) return ST_BAD_CRC;
		// a saturated counter means 1023 bytes or more
		if (n == 10'h3FF) return ST_INCONSISTENT;
		if (n == 10'd8) return ST_NO_PAYLOAD;
		if (n[1:0] != 2'd0) return ST_BAD_PADDING;
		pad  = 2'd0 - hdr_len[1:0];
		span = 18'd8 + hdr_len + pad;
		if (span != {8'd0, n}) return ST_INCONSISTENT;
		return ST_OK;
	endfunction

	// Advance the model by one accepted byte and queue whatever it yields
	function void decode_byte(input in_t d);
		logic [9:0]  c;
		logic [7:0]  leaving;
		logic        emit;
		logic [31:0] rx_crc;
		out_t        r;
		c       = rx_count;
		leaving = tail[0];
		case (c)
			10'd0: begin
				hdr_type = d.rx_byte[7:5];
				hdr_win  = d.rx_byte[4:0];
			end
			10'd1: hdr_seq = d.rx_byte;
			10'd2: hdr_len[15:8] = d.rx_byte;
			10'd3: hdr_len[7:0] = d.rx_byte;
			default: ;
		endcase
		if (c >= 10'd4) crc_run = crc_step(crc_run, leaving);
		emit = (c != 10'h3FF) && (c >= 10'd8) && (({6'd0, c} - 16'd8) < hdr_len);
		tail[0] = tail[1];
		tail[1] = tail[2];
		tail[2] = tail[3];
		tail[3] = d.rx_byte;
		if (c != 10'h3FF) rx_count = c + 10'd1;

		r = '0;
		r.payload_valid = emit;
		r.payload_byte  = emit ? leaving : 8'd0;
		if (d.end_of_packet) begin
			rx_crc            = {tail[0], tail[1], tail[2], tail[3]};
			r.done_res        = 1'b1;
			r.status          = judge(rx_count, rx_crc);
			r.packet_type     = hdr_type;
			r.window_size     = hdr_win;
			r.sequence_number = hdr_seq;
			r.payload_length  = hdr_len;
			r.trailer_crc     = rx_crc;
			clear_packet();
		end
		if (emit || d.end_of_packet) due_results.push_back(r);
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	task automatic report(input string msg);
		if (errors < PRINT_CAP) $display("%0t ns  mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	// ------------------------------------------------------------------------
	// Driver: present the next byte whenever the input slot is free
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else if (!in_valid || in_ready) begin
			// hold valid and payload until the transaction is taken
			if (rx_stream.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
				in_valid <= 1'b1;
				in_data  <= rx_stream.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: check output transactions first, then advance the model on
	// input transactions of the same edge
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			clear_packet();
		end else begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					report($sformatf("result with nothing due (done_res %0b, byte 0x%0h)",
						out_data.done_res, out_data.payload_byte));
				end else begin
					want = due_results.pop_front();
					check_field("payload_valid", out_data.payload_valid, want.payload_valid);
					check_field("payload_byte", out_data.payload_byte, want.payload_byte);
					check_field("done_res", out_data.done_res, want.done_res);
					check_field("status", out_data.status, want.status);
					check_field("packet_type", out_data.packet_type, want.packet_type);
					check_field("window_size", out_data.window_size, want.window_size);
					check_field("sequence_number", out_data.sequence_number,
						want.sequence_number);
					check_field("payload_length", out_data.payload_length,
						want.payload_length);
					check_field("trailer_crc", out_data.trailer_crc, want.trailer_crc);
				end
			end
			if (in_valid && in_ready) decode_byte(in_data);
			out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog: give up well past the slowest plausible run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Write one register and mirror it into the model
	task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_MAX_WINDOW: lim_window = val;
			CFG_DATA_TYPE:  code_data  = val[2:0];
			CFG_ACK_TYPE:   code_ack   = val[2:0];
			CFG_NACK_TYPE:  code_nack  = val[2:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold until every byte is taken and every result is in, then let any
	// byte still in the input register drain through
	task automatic wait_idle();
		do @(negedge clk);
		while (rx_stream.size() != 0 || in_valid || due_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Header, body of random bytes, then the big-endian CRC of all before it
	task automatic build_frame(input logic [2:0] ptype, input logic [4:0] win,
			input logic [15:0] len, input int body, input bit crc_ok);
		logic [31:0] acc;
		frame.delete();
		frame.push_back({ptype, win});
		frame.push_back(8'($urandom));
		frame.push_back(len[15:8]);
		frame.push_back(len[7:0]);
		repeat (body) frame.push_back(8'($urandom));
		acc = '1;
		foreach (frame[i]) acc = crc_step(acc, frame[i]);
		acc = ~acc;
		if (!crc_ok) acc ^= 32'd1 << $urandom_range(31);
		frame.push_back(acc[31:24]);
		frame.push_back(acc[23:16]);
		frame.push_back(acc[15:8]);
		frame.push_back(acc[7:0]);
	endtask

	// Queue the first keep bytes of the frame, flagging the last of them
	task automatic send_frame(input int keep);
		in_t item;
		for (int i = 0; i < keep; i++) begin
			item.rx_byte       = frame[i];
			item.end_of_packet = (i == keep - 1);
			rx_stream.push_back(item);
		end
	endtask

	// One frame of a random kind; mostly well-formed data frames
	task automatic random_frame(output int sent);
		int          pick;
		int          body;
		int          delta;
		logic [2:0]  ptype;
		logic [4:0]  win;
		logic [15:0] len;
		pick  = $urandom_range(99);
		ptype = code_data;
		win   = 5'($urandom_range(lim_window, 0));
		if ($urandom_range(39) == 0)
			len = ($urandom_range(1) == 1) ? 16'd512 : 16'($urandom_range(512, 100));
		else
			len = 16'($urandom_range(24));
		body = len + (4 - len % 4) % 4;

		if (pick >= 62 && pick < 67) begin
			ptype = ($urandom_range(1) == 1) ? code_ack : code_nack;
		end else if (pick >= 67 && pick < 72) begin
			// a type code that none of the registers holds
			do ptype = 3'($urandom_range(7));
			while (ptype == code_data || ptype == code_ack || ptype == code_nack);
		end else if (pick >= 72 && pick < 77 && lim_window != 5'd31) begin
			win = 5'($urandom_range(31, lim_window + 1));
		end else if (pick >= 77 && pick < 81) begin
			len  = 16'($urandom_range(65535, 513));
			body = $urandom_range(8);
		end else if (pick >= 81 && pick < 87) begin
			// body off by a few bytes: padding or length disagrees
			delta = $urandom_range(9) - 3;
			if (delta >= 0) delta++;
			body = (body + delta < 0) ? 0 : body + delta;
		end
		// a corrupted CRC for one band of frames
		build_frame(ptype, win, len, body, !(pick >= 55 && pick < 62));

		if (pick >= 87 && pick < 93) begin
			sent = $urandom_range(frame.size() - 1, 1);
		end else if (pick >= 93) begin
			// raw noise of random length
			sent = $urandom_range(12, 1);
			frame.delete();
			repeat (sent) frame.push_back(8'($urandom));
		end else if (pick >= 62 && pick < 67 && $urandom_range(1) == 1) begin
			sent = 4;  // header-only control frame
		end else begin
			sent = frame.size();
		end
		send_frame(sent);
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		int sent;
		int phase_bytes;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed frames under the reset configuration
		frame = '{8'hFF};                       // single byte: no header
		send_frame(1);
		frame = '{8'h00, 8'h80, 8'h00};         // three bytes: still no header
		send_frame(3);
		build_frame(3'd1, 5'd31, 16'd0, 0, 1'b1);
		send_frame(4);                          // header alone, all checks pass
		build_frame(3'd0, 5'd5, 16'd0, 0, 1'b1);
		send_frame(4);                          // type outside every code
		build_frame(3'd1, 5'd0, 16'hFFFF, 0, 1'b1);
		send_frame(4);                          // declared length far too big
		build_frame(3'd1, 5'd17, 16'd0, 0, 1'b1);
		send_frame(frame.size());               // CRC but no payload
		wait_idle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_MAX_WINDOW, 5'd31);
					write_reg(CFG_DATA_TYPE, 5'd1);
					write_reg(CFG_ACK_TYPE, 5'd2);
					write_reg(CFG_NACK_TYPE, 5'd3);
				end
				1: begin
					// smallest window limit, codes at both ends and coinciding
					write_reg(CFG_MAX_WINDOW, 5'd0);
					write_reg(CFG_DATA_TYPE, 5'd0);
					write_reg(CFG_ACK_TYPE, 5'd7);
					write_reg(CFG_NACK_TYPE, 5'd7);
				end
				2: begin
					write_reg(CFG_MAX_WINDOW, 5'd15);
					write_reg(CFG_DATA_TYPE, 5'd7);
					write_reg(CFG_ACK_TYPE, 5'd0);
					write_reg(CFG_NACK_TYPE, 5'd4);
				end
				4: begin
					// all three codes the same
					write_reg(CFG_MAX_WINDOW, 5'd31);
					write_reg(CFG_DATA_TYPE, 5'd5);
					write_reg(CFG_ACK_TYPE, 5'd5);
					write_reg(CFG_NACK_TYPE, 5'd5);
				end
				default: begin
					write_reg(CFG_MAX_WINDOW, 5'($urandom_range(31)));
					write_reg(CFG_DATA_TYPE, 5'($urandom_range(7)));
					write_reg(CFG_ACK_TYPE, 5'($urandom_range(7)));
					write_reg(CFG_NACK_TYPE, 5'($urandom_range(7)));
				end
			endcase
			@(negedge clk);
			// one phase runs flat out on both channels
			steady = (ph == 2);

			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				random_frame(sent);
				phase_bytes += sent;
			end
			if (ph == 3) begin
				// over-long frame: the byte counter saturates
				build_frame(code_data, 5'($urandom_range(lim_window, 0)),
					16'($urandom_range(512)), $urandom_range(1022, 1015), 1'b1);
				send_frame(frame.size());
			end
			wait_idle();
		end

		if (errors == 0 && due_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			if (due_results.size() != 0)
				report($sformatf("%0d results never arrived", due_results.size()));
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> sim.f
sv/cpd_pkg.sv
sv/cpd_verdict.sv
sv/cpd_core.sv
sv/crc_checked_packet_decoder_top.sv
dv/tb_crc_checked_packet_decoder_top.sv
